/* design/psfd_pkg.sv */
// ----------------------------------------------------------------------------
// psfd_pkg
// Types and constants shared by the per-source flood detect table.
// ----------------------------------------------------------------------------
package psfd_pkg;

    localparam int RULE_W   = 16;
    localparam int MAC_W    = 48;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;
    localparam int LIMIT_W  = 16;
    localparam int TOTAL_W  = 16;
    localparam int OUTC_W   = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUTC_COUNTED = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_NEW     = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_CLEARED = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_ATTACK  = 2'd3;

    typedef struct packed {
        logic [RULE_W-1:0]  rule;
        logic [MAC_W-1:0]   mac;
        logic [TIME_W-1:0]  start;
        logic [TOTAL_W-1:0] total;
        logic               disabled;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* design/per_source_flood_detect_table.sv */
// ----------------------------------------------------------------------------
// per_source_flood_detect_table
// Counts frames per rule id and source MAC and flags sources that flood.
// ----------------------------------------------------------------------------
// On a hit the scan stops at the first matching entry; on a miss every used
// entry is read and compared before the item moves on to the append. Against
// an empty table the item goes straight to the append. The used entries are
// read one per cycle from the single read port of the entry RAM and compared
// in the cycle after the read. The S_HIT or S_MISS state then updates the
// entry and loads the result register. The input is stalled until that state
// is left, so the next transfer can come in the same cycle as the result
// appears. A result still waiting at the output holds the finish of the next
// item. Appending into the last free slot clears the table by resetting the
// fill count only, so no clearing pass is run and the table is ready right
// after reset.
// ----------------------------------------------------------------------------
module per_source_flood_detect_table #(
    parameter int ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] rule_id,
    input  logic [47:0] src_mac,
    input  logic [31:0] now_seconds,
    input  logic [15:0] window_seconds,
    input  logic [15:0] count_limit,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  outcome,
    output logic [15:0] entry_count
);

    localparam int AW = $clog2(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          issue_done_reg, issue_done_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;

    logic [psfd_pkg::RULE_W-1:0]   rule_reg, rule_next;
    logic [psfd_pkg::MAC_W-1:0]    mac_reg, mac_next;
    logic [psfd_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [psfd_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [psfd_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic [psfd_pkg::TIME_W-1:0]   start_reg, start_next;
    logic [psfd_pkg::TOTAL_W-1:0]  total_reg, total_next;

    logic                          out_valid_reg, out_valid_next;
    logic [psfd_pkg::OUTC_W-1:0]   outcome_reg, outcome_next;
    logic [psfd_pkg::TOTAL_W-1:0]  count_reg, count_next;

    logic                          rd_en;
    logic [psfd_pkg::ENTRY_W-1:0]  rd_word;
    psfd_pkg::entry_t              rd_entry;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    psfd_pkg::entry_t              wr_entry;

    logic                          in_xfer;
    logic                          out_free;
    logic                          match;
    logic [AW-1:0]                 last_idx;
    logic [psfd_pkg::TOTAL_W-1:0]  total_inc;
    logic [psfd_pkg::TIME_W:0]     expire_time;
    logic                          attack;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign entry_count = count_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign rd_entry = psfd_pkg::entry_t'(rd_word);
    assign last_idx = fill_reg - AW'(1);
    assign match    = (rd_entry.rule == rule_reg) && !rd_entry.disabled
                      && (rd_entry.mac == mac_reg);

    // saturating count and window check for the hit entry
    assign total_inc   = (total_reg == psfd_pkg::TOTAL_MAX) ? total_reg
                         : total_reg + psfd_pkg::TOTAL_W'(1);
    assign expire_time = {1'b0, start_reg} + (psfd_pkg::TIME_W + 1)'(window_reg);
    assign attack      = (expire_time <= {1'b0, now_reg})
                         && (total_inc > limit_reg);

    assign rd_en = (state_reg == S_SCAN) && !issue_done_reg;

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = hit_idx_reg;
        wr_entry = '{rule: rule_reg, mac: mac_reg, start: start_reg,
                     total: total_inc, disabled: attack};
        if (state_reg == S_HIT)
        begin
            wr_en = out_free;
        end
        else if (state_reg == S_MISS)
        begin
            wr_en    = out_free;
            wr_addr  = fill_reg;
            wr_entry = '{rule: rule_reg, mac: mac_reg, start: now_reg,
                         total: psfd_pkg::TOTAL_W'(1), disabled: 1'b0};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rd_ptr_next     = rd_ptr_reg;
        issue_done_next = issue_done_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = rd_ptr_reg;
        hit_idx_next    = hit_idx_reg;
        rule_next       = rule_reg;
        mac_next        = mac_reg;
        now_next        = now_reg;
        window_next     = window_reg;
        limit_next      = limit_reg;
        start_next      = start_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg && out_stall;
        outcome_next    = outcome_reg;
        count_next      = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    rule_next       = rule_id;
                    mac_next        = src_mac;
                    now_next        = now_seconds;
                    window_next     = window_seconds;
                    limit_next      = count_limit;
                    rd_ptr_next     = '0;
                    issue_done_next = 1'b0;
                    // empty table: straight to append
                    state_next      = (fill_reg == '0) ? S_MISS : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    cmp_valid_next = 1'b1;
                    if (rd_ptr_reg == last_idx)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
                if (cmp_valid_reg)
                begin
                    if (match)
                    begin
                        hit_idx_next = cmp_idx_reg;
                        start_next   = rd_entry.start;
                        total_next   = rd_entry.total;
                        state_next   = S_HIT;
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        state_next = S_MISS;
                    end
                end
            end
            S_HIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    outcome_next   = attack ? psfd_pkg::OUTC_ATTACK
                                            : psfd_pkg::OUTC_COUNTED;
                    count_next     = total_inc;
                    state_next     = S_IDLE;
                end
            end
            S_MISS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (fill_reg == AW'(ENTRIES - 1))
                    begin
                        // table full: drop every entry
                        fill_next    = '0;
                        outcome_next = psfd_pkg::OUTC_CLEARED;
                        count_next   = '0;
                    end
                    else
                    begin
                        fill_next    = fill_reg + AW'(1);
                        outcome_next = psfd_pkg::OUTC_NEW;
                        count_next   = psfd_pkg::TOTAL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
            issue_done_reg <= issue_done_next;
            cmp_valid_reg  <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        rule_reg    <= rule_next;
        mac_reg     <= mac_next;
        now_reg     <= now_next;
        window_reg  <= window_next;
        limit_reg   <= limit_next;
        start_reg   <= start_next;
        total_reg   <= total_next;
        outcome_reg <= outcome_next;
        count_reg   <= count_next;
    end

    psfd_ram #(
        .WIDTH (psfd_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (psfd_pkg::ENTRY_W'(wr_entry)),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_word)
    );

endmodule

/* design/psfd_ram.sv */
// ----------------------------------------------------------------------------
// psfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psfd_ram #(
    parameter int WIDTH = 113,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the per-source flood detect table against its own table predictor.
// Directed frames cover the field extremes, window edges, limits, disabled
// entries and empty-table searches. A steady run fills the table to a clear
// and then counts one entry up with no idling. Random bursts of frames over
// small and large key pools then drive fills, table clears and attacks, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH         = 64;
    localparam int POOL_MAX      = 90;
    localparam int RANDOM_FRAMES = 1130;
    localparam int QUIET_LIMIT   = 4000;
    localparam int STEADY_HITS   = 40;

    typedef struct packed {
        logic [psfd_pkg::OUTC_W-1:0]  outcome;
        logic [psfd_pkg::TOTAL_W-1:0] count;
    } report_t;

    // Table predictor plus the queue of reports it still owes.
    class flood_scoreboard;
        psfd_pkg::entry_t slots [DEPTH];
        int               fill;
        report_t          due [$];
        int               failures;
        int               seen [4];
        int               peak;

        function new();
            clear_slots();
            failures = 0;
            peak     = 0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function void clear_slots();
            fill = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void note_frame(logic [psfd_pkg::RULE_W-1:0] rid,
                                 logic [psfd_pkg::MAC_W-1:0] mac,
                                 logic [psfd_pkg::TIME_W-1:0] now,
                                 logic [psfd_pkg::WINDOW_W-1:0] win,
                                 logic [psfd_pkg::LIMIT_W-1:0] lim);
            int          i;
            int          hit_at;
            logic [32:0] deadline;
            report_t     r;
            hit_at = -1;
            for (i = 0; i < fill; i++)
                if (hit_at < 0 && slots[i].rule == rid && !slots[i].disabled &&
                    slots[i].mac == mac)
                    hit_at = i;
            if (hit_at < 0) begin
                slots[fill].rule     = rid;
                slots[fill].mac      = mac;
                slots[fill].start    = now;
                slots[fill].total    = psfd_pkg::TOTAL_W'(1);
                slots[fill].disabled = 1'b0;
                fill++;
                if (fill == DEPTH) begin
                    clear_slots();
                    r.outcome = psfd_pkg::OUTC_CLEARED;
                    r.count   = '0;
                end
                else begin
                    r.outcome = psfd_pkg::OUTC_NEW;
                    r.count   = psfd_pkg::TOTAL_W'(1);
                end
            end
            else begin
                if (slots[hit_at].total != psfd_pkg::TOTAL_MAX)
                    slots[hit_at].total++;
                // window end taken without wrap
                deadline = {1'b0, slots[hit_at].start} + {17'b0, win};
                if (deadline <= {1'b0, now} && slots[hit_at].total > lim) begin
                    slots[hit_at].disabled = 1'b1;
                    r.outcome = psfd_pkg::OUTC_ATTACK;
                end
                else
                    r.outcome = psfd_pkg::OUTC_COUNTED;
                r.count = slots[hit_at].total;
            end
            due.push_back(r);
        endfunction

        function void check_report(logic [psfd_pkg::OUTC_W-1:0] oc,
                                   logic [psfd_pkg::TOTAL_W-1:0] cnt);
            report_t want;
            if (due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected report outcome %0d count %0d",
                             $realtime, oc, cnt);
                return;
            end
            want = due.pop_front();
            seen[want.outcome]++;
            if (want.count > peak) peak = want.count;
            if (oc !== want.outcome || cnt !== want.count) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: report mismatch: outcome %0d (want %0d), %s",
                             $realtime, oc, want.outcome,
                             $sformatf("count %0d (want %0d)", cnt, want.count));
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        rule_id;
    logic [47:0]        src_mac;
    logic [31:0]        now_seconds;
    logic [15:0]        window_seconds;
    logic [15:0]        count_limit;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         outcome;
    logic [15:0]        entry_count;

    flood_scoreboard    sb = new();
    bit                 steady = 1'b0;
    int                 frames_sent = 0;
    int                 quiet_cycles = 0;

    per_source_flood_detect_table #(
        .ENTRIES        (DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rule_id        (rule_id),
        .src_mac        (src_mac),
        .now_seconds    (now_seconds),
        .window_seconds (window_seconds),
        .count_limit    (count_limit),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .entry_count    (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // random backpressure on the result side
    always @(negedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 18);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_report(outcome, entry_count);
    end

    // end the run once nothing has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT) begin
            $display("no transfer for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_frame(input logic [15:0] rid, input logic [47:0] mac,
                              input logic [31:0] now, input logic [15:0] win,
                              input logic [15:0] lim);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 18) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        rule_id        <= rid;
        src_mac        <= mac;
        now_seconds    <= now;
        window_seconds <= win;
        count_limit    <= lim;
        in_valid       <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_frame(rid, mac, now, win, lim);
        frames_sent++;
        // drop valid while the table works on this frame
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge clk);
    endtask

    // zero, a small value, anything, or the top of the range
    function automatic logic [15:0] pick_bound(int small_hi);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'($urandom_range(1, small_hi));
            2:       return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic run_burst();
        logic [15:0] pool_rule [POOL_MAX];
        logic [47:0] pool_mac [POOL_MAX];
        logic [31:0] now;
        logic [15:0] win;
        logic [15:0] lim;
        int          keys;
        int          frames;
        int          pick;
        int          idx;
        int          k;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            keys = $urandom_range(1, 6);
        else if (pick < 9)
            keys = $urandom_range(7, 24);
        else
            keys = $urandom_range(40, POOL_MAX);
        // some keys share a rule or a MAC with the first one
        for (k = 0; k < keys; k++) begin
            pool_rule[k] = (k > 0 && $urandom_range(0, 3) == 0) ? pool_rule[0]
                                                                : 16'($urandom);
            pool_mac[k]  = (k > 0 && $urandom_range(0, 3) == 0) ? pool_mac[0]
                                                                : 48'({$urandom, $urandom});
        end
        case ($urandom_range(0, 3))
            0:       now = $urandom_range(0, 15);
            1:       now = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: now = $urandom;
        endcase
        win    = pick_bound(8);
        lim    = pick_bound(6);
        frames = $urandom_range(4, 40);
        for (k = 0; k < frames; k++) begin
            now = now + $urandom_range(0, 3);
            idx = $urandom_range(0, keys - 1);
            if ($urandom_range(0, 99) < 12)
                send_frame(16'($urandom), 48'({$urandom, $urandom}), $urandom,
                           16'($urandom), 16'($urandom));
            else if ($urandom_range(0, 99) < 10)
                send_frame(pool_rule[idx], pool_mac[idx], now, pick_bound(8), pick_bound(6));
            else
                send_frame(pool_rule[idx], pool_mac[idx], now, win, lim);
        end
    endtask

    initial
    begin
        logic [47:0] hot_mac;
        int          bursts;
        int          k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        rule_id        = '0;
        src_mac        = '0;
        now_seconds    = '0;
        window_seconds = '0;
        count_limit    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, then an immediate alarm with zero window and limit
        send_frame(16'h0000, 48'h0, 32'h0, 16'h0, 16'h0);
        send_frame(16'h0000, 48'h0, 32'h0, 16'h0, 16'h0);
        // disabled entry no longer matches
        send_frame(16'h0000, 48'h0, 32'd5, 16'h0, 16'h0);
        // all-ones fields: window end lies past the 32-bit time range
        send_frame(16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_frame(16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        // partial key matches are misses
        send_frame(16'hFFFF, 48'h0, 32'd100, 16'd10, 16'd0);
        send_frame(16'h1234, 48'hFFFF_FFFF_FFFF, 32'd100, 16'd10, 16'd0);
        // one second short of the window end, then exactly at it
        send_frame(16'hFFFF, 48'h0, 32'd109, 16'd10, 16'd0);
        send_frame(16'hFFFF, 48'h0, 32'd110, 16'd10, 16'd0);
        // count equal to the limit holds, one above it alarms
        send_frame(16'hA5A5, 48'h5A5A_5A5A_5A5A, 32'd1000, 16'd0, 16'd3);
        send_frame(16'hA5A5, 48'h5A5A_5A5A_5A5A, 32'd1000, 16'd0, 16'd3);
        send_frame(16'hA5A5, 48'h5A5A_5A5A_5A5A, 32'd1000, 16'd0, 16'd3);
        send_frame(16'hA5A5, 48'h5A5A_5A5A_5A5A, 32'd1000, 16'd0, 16'd3);
        send_frame(16'h1234, 48'hFFFF_FFFF_FFFF, 32'd200, 16'd10, 16'hFFFF);
        send_frame(16'h0001, 48'h0000_0000_0001, 32'h8000_0000, 16'h8000, 16'h8000);
        wait_drained();

        // fill up to a clear with no idling, then count one entry up
        steady = 1'b1;
        while (sb.fill != 0)
            send_frame(16'($urandom), 48'({$urandom, $urandom}), $urandom,
                       16'($urandom), 16'($urandom));
        hot_mac = 48'({$urandom, $urandom});
        send_frame(16'hBEEF, hot_mac, 32'h1000, 16'h0, 16'hFFFF);
        for (k = 0; k < STEADY_HITS; k++)
            send_frame(16'hBEEF, hot_mac, 32'h1000, 16'h0, 16'hFFFF);
        send_frame(16'hBEEF, hot_mac, 32'h1000, 16'h0, 16'hFFFE);
        steady = 1'b0;

        bursts = 0;
        k = frames_sent;
        while (frames_sent < k + RANDOM_FRAMES) begin
            run_burst();
            bursts++;
            // hold off until the table has answered everything
            if (bursts % 8 == 7)
                wait_drained();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);
        $display("%0d frames: directed cases, a steady run and %0d random bursts",
                 frames_sent, bursts);
        $display("reports: %0d new, %0d counted, %0d attacks, %0d clears; peak count %0d",
                 sb.seen[psfd_pkg::OUTC_NEW], sb.seen[psfd_pkg::OUTC_COUNTED],
                 sb.seen[psfd_pkg::OUTC_ATTACK], sb.seen[psfd_pkg::OUTC_CLEARED],
                 sb.peak);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
